// File: rtl/core/phl_pkg.sv
package phl_pkg;

	localparam int unsigned SQ_STEPS = 18;	// root bits of a 36-bit radicand
	localparam int unsigned RC_STEPS = 19;	// quotient bits of 2^34 / root

	localparam logic [2:0] REG_SURFACE   = 3'd0;
	localparam logic [2:0] REG_LIGHT_RGB = 3'd1;
	localparam logic [2:0] REG_LIGHT_X   = 3'd2;
	localparam logic [2:0] REG_LIGHT_Y   = 3'd3;
	localparam logic [2:0] REG_LIGHT_Z   = 3'd4;
	localparam logic [2:0] REG_COEFFS    = 3'd5;
	localparam logic [2:0] REG_SHININESS = 3'd6;

	localparam logic [15:0] SHININESS_RST = 16'd51200;

	// item payload carried through the normalize units
	typedef struct packed {
		logic [2:0][14:0] mag;
		logic [2:0]       neg;
		logic             zero;
		logic             shadow;
		logic [2:0][15:0] eye;
		logic [2:0][15:0] nrm;
	} vec_pay_t;

	// item payload carried through the power unit
	typedef struct packed {
		logic [19:0] d;
		logic        dif_on;
		logic        spec_on;
	} pw_pay_t;

	// index of the highest set bit, 0 for an all-zero word
	function automatic logic [5:0] lead_one(input logic [32:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [16:0] log_tab(input logic [4:0] i);
		logic [16:0] r;
		case (i)
			5'd0:  r = 17'd0;
			5'd1:  r = 17'd5732;
			5'd2:  r = 17'd11136;
			5'd3:  r = 17'd16248;
			5'd4:  r = 17'd21098;
			5'd5:  r = 17'd25711;
			5'd6:  r = 17'd30109;
			5'd7:  r = 17'd34312;
			5'd8:  r = 17'd38336;
			5'd9:  r = 17'd42196;
			5'd10: r = 17'd45904;
			5'd11: r = 17'd49472;
			5'd12: r = 17'd52911;
			5'd13: r = 17'd56229;
			5'd14: r = 17'd59434;
			5'd15: r = 17'd62534;
			5'd16: r = 17'd65536;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	function automatic logic [17:0] exp_tab(input logic [4:0] i);
		logic [17:0] r;
		case (i)
			5'd0:  r = 18'd65536;
			5'd1:  r = 18'd68438;
			5'd2:  r = 18'd71468;
			5'd3:  r = 18'd74632;
			5'd4:  r = 18'd77936;
			5'd5:  r = 18'd81386;
			5'd6:  r = 18'd84990;
			5'd7:  r = 18'd88752;
			5'd8:  r = 18'd92682;
			5'd9:  r = 18'd96785;
			5'd10: r = 18'd101070;
			5'd11: r = 18'd105545;
			5'd12: r = 18'd110218;
			5'd13: r = 18'd115098;
			5'd14: r = 18'd120194;
			5'd15: r = 18'd125515;
			5'd16: r = 18'd131072;
			default: r = 18'd131072;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/phong_lighting_shader.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    point_*, eye_*, normal_*, in_shadow
// out      output     out_valid/out_ready  shade_red, shade_green, shade_blue
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the pipe advances; 5 setup stages, 18 square root
// stages, 19 divider stages, 7 vector stages, 5 power stages, 2 output stages.
// The last stage is the output register. All stages advance together while
// the output register is empty or being taken; otherwise the whole pipe holds.
// Reset clears valid bits and config but shininess; cfg_ready is always high.
module phong_lighting_shader import phl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [15:0] eye_x,
	input  logic signed [15:0] eye_y,
	input  logic signed [15:0] eye_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic               in_shadow,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        shade_red,
	output logic [15:0]        shade_green,
	output logic [15:0]        shade_blue,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	logic en;

	// configuration
	logic [47:0] surf_q, lrgb_q, coef_q;
	logic [31:0] lx_q, ly_q, lz_q;
	logic [15:0] shin_q;
	logic [19:0] e_q   [3];
	logic [21:0] amb_q [3];
	logic [35:0] ekd_q [3];
	logic [31:0] lks_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_q <= '0;
			lrgb_q <= '0;
			lx_q   <= '0;
			ly_q   <= '0;
			lz_q   <= '0;
			coef_q <= '0;
			shin_q <= SHININESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SURFACE:   surf_q <= cfg_data;
				REG_LIGHT_RGB: lrgb_q <= cfg_data;
				REG_LIGHT_X:   lx_q   <= cfg_data[31:0];
				REG_LIGHT_Y:   ly_q   <= cfg_data[31:0];
				REG_LIGHT_Z:   lz_q   <= cfg_data[31:0];
				REG_COEFFS:    coef_q <= cfg_data;
				REG_SHININESS: shin_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// color products depend on configuration only; settled long before use
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e_q[i]   <= 20'((32'(surf_q[47-16*i -: 16]) * 32'(lrgb_q[47-16*i -: 16])) >> 12);
			amb_q[i] <= 22'((36'(e_q[i]) * 36'(coef_q[47:32])) >> 14);
			ekd_q[i] <= 36'(e_q[i]) * 36'(coef_q[31:16]);
			lks_q[i] <= 32'(lrgb_q[47-16*i -: 16]) * 32'(coef_q[15:0]);
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// s1: light minus point, magnitudes
	logic signed [32:0] dif [3];
	assign dif[0] = {lx_q[31], lx_q} - {point_x[31], point_x};
	assign dif[1] = {ly_q[31], ly_q} - {point_y[31], point_y};
	assign dif[2] = {lz_q[31], lz_q} - {point_z[31], point_z};

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [32:0]        mag_s1 [3];
	logic [2:0]         neg_s1;
	logic signed [15:0] eye_s1 [3];
	logic signed [15:0] nrm_s1 [3];
	logic               shd_s1;

	logic [32:0]        mag_s2 [3];
	logic [32:0]        m_s2;
	logic [2:0]         neg_s2;
	logic signed [15:0] eye_s2 [3];
	logic signed [15:0] nrm_s2 [3];
	logic               shd_s2;

	logic [32:0]        mag_s3 [3];
	logic [5:0]         p_s3;
	logic               zero_s3;
	logic [2:0]         neg_s3;
	logic signed [15:0] eye_s3 [3];
	logic signed [15:0] nrm_s3 [3];
	logic               shd_s3;

	vec_pay_t           c_s4;
	vec_pay_t           c_s5;
	logic [31:0]        q_s5;

	logic [32:0] m01;
	logic [32:0] sh_mag [3];
	assign m01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (p_s3 >= 6'd14) begin
				sh_mag[i] = 33'(mag_s3[i] >> (p_s3 - 6'd14));
			end else begin
				sh_mag[i] = 33'(mag_s3[i] << (6'd14 - p_s3));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= dif[i][32];
				mag_s1[i] <= dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
			end
			eye_s1[0] <= eye_x;
			eye_s1[1] <= eye_y;
			eye_s1[2] <= eye_z;
			nrm_s1[0] <= normal_x;
			nrm_s1[1] <= normal_y;
			nrm_s1[2] <= normal_z;
			shd_s1    <= in_shadow;

			mag_s2 <= mag_s1;
			m_s2   <= (mag_s1[2] > m01) ? mag_s1[2] : m01;
			neg_s2 <= neg_s1;
			eye_s2 <= eye_s1;
			nrm_s2 <= nrm_s1;
			shd_s2 <= shd_s1;

			// block scaling: leading one of the largest magnitude to bit 14
			mag_s3  <= mag_s2;
			p_s3    <= lead_one(m_s2);
			zero_s3 <= (m_s2 == 33'd0);
			neg_s3  <= neg_s2;
			eye_s3  <= eye_s2;
			nrm_s3  <= nrm_s2;
			shd_s3  <= shd_s2;

			for (int i = 0; i < 3; i++) begin
				c_s4.mag[i] <= sh_mag[i][14:0];
				c_s4.eye[i] <= eye_s3[i];
				c_s4.nrm[i] <= nrm_s3[i];
			end
			c_s4.neg    <= neg_s3;
			c_s4.zero   <= zero_s3;
			c_s4.shadow <= shd_s3;

			q_s5 <= 32'(c_s4.mag[0]) * 32'(c_s4.mag[0])
			      + 32'(c_s4.mag[1]) * 32'(c_s4.mag[1])
			      + 32'(c_s4.mag[2]) * 32'(c_s4.mag[2]);
			c_s5 <= c_s4;
		end
	end

	// root = isqrt(16 q), rcp = 2^34 / root
	logic        vld_sq, vld_rc;
	logic [17:0] root_sq;
	vec_pay_t    c_sq, c_rc;
	logic [18:0] rcp_rc;

	phl_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_v     ({q_s5, 4'b0000}),
		.in_pay   (c_s5),
		.out_vld  (vld_sq),
		.out_root (root_sq),
		.out_pay  (c_sq)
	);

	phl_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_sq),
		.in_root (root_sq),
		.in_pay  (c_sq),
		.out_vld (vld_rc),
		.out_rcp (rcp_rc),
		.out_pay (c_rc)
	);

	// vector stages
	logic               vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic signed [16:0] l_s6 [3], l_s7 [3], l_s8 [3], l_s9 [3];
	logic signed [15:0] eye_s6 [3], eye_s7 [3], eye_s8 [3], eye_s9 [3], eye_s10 [3];
	logic signed [15:0] nrm_s6 [3], nrm_s7 [3], nrm_s8 [3];
	logic               shd_s6, shd_s7, shd_s8, shd_s9, shd_s10, shd_s11;
	logic signed [32:0] pn_s7 [3];
	logic signed [34:0] ln_s8, ln_s9, ln_s10, ln_s11;
	logic signed [50:0] lnn_s9 [3];
	logic signed [24:0] r_s10 [3];
	logic signed [40:0] re_s11 [3];
	logic [28:0]        x_s12;
	pw_pay_t            pw_s12;

	logic [33:0]        uprod [3];
	logic signed [42:0] rde;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uprod[i] = 34'(c_rc.mag[i]) * 34'(rcp_rc);
		end
	end

	assign rde = 43'(re_s11[0]) + 43'(re_s11[1]) + 43'(re_s11[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s6  <= vld_rc;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// light at the point gives a zero direction
			for (int i = 0; i < 3; i++) begin
				if (c_rc.zero) begin
					l_s6[i] <= '0;
				end else if (c_rc.neg[i]) begin
					l_s6[i] <= -$signed({1'b0, uprod[i][33:18]});
				end else begin
					l_s6[i] <= $signed({1'b0, uprod[i][33:18]});
				end
				eye_s6[i] <= $signed(c_rc.eye[i]);
				nrm_s6[i] <= $signed(c_rc.nrm[i]);
			end
			shd_s6 <= c_rc.shadow;

			for (int i = 0; i < 3; i++) begin
				pn_s7[i] <= 33'(l_s6[i]) * 33'(nrm_s6[i]);
			end
			l_s7   <= l_s6;
			eye_s7 <= eye_s6;
			nrm_s7 <= nrm_s6;
			shd_s7 <= shd_s6;

			ln_s8  <= 35'(pn_s7[0]) + 35'(pn_s7[1]) + 35'(pn_s7[2]);
			l_s8   <= l_s7;
			eye_s8 <= eye_s7;
			nrm_s8 <= nrm_s7;
			shd_s8 <= shd_s7;

			for (int i = 0; i < 3; i++) begin
				lnn_s9[i] <= 51'(ln_s8) * 51'(nrm_s8[i]);
			end
			ln_s9  <= ln_s8;
			l_s9   <= l_s8;
			eye_s9 <= eye_s8;
			shd_s9 <= shd_s8;

			// reflected direction, floor of 2 ln N / 2^28
			for (int i = 0; i < 3; i++) begin
				r_s10[i] <= 25'(lnn_s9[i] >>> 27) - 25'(l_s9[i]);
			end
			ln_s10  <= ln_s9;
			eye_s10 <= eye_s9;
			shd_s10 <= shd_s9;

			for (int i = 0; i < 3; i++) begin
				re_s11[i] <= 41'(r_s10[i]) * 41'(eye_s10[i]);
			end
			ln_s11  <= ln_s10;
			shd_s11 <= shd_s10;

			x_s12          <= (rde > 43'sd268435456) ? 29'h10000000 : rde[28:0];
			pw_s12.d       <= ln_s11[33:14];
			pw_s12.dif_on  <= !ln_s11[34] && !shd_s11;
			pw_s12.spec_on <= (rde > 43'sd0);
		end
	end

	logic        vld_pw;
	logic [16:0] factor_pw;
	pw_pay_t     pw_out;

	phl_power u_power (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s12),
		.x       (x_s12),
		.sh      (shin_q),
		.in_pay  (pw_s12),
		.out_vld (vld_pw),
		.factor  (factor_pw),
		.out_pay (pw_out)
	);

	// output stages
	logic        vld_f1;
	logic        dif_f1;
	logic [27:0] dt_f1 [3];
	logic [18:0] st_f1 [3];
	logic [15:0] shade_f2 [3];
	logic        vld_f2;

	logic [55:0] dprod [3];
	logic [48:0] sprod [3];
	logic [28:0] sum   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dprod[i] = 56'(ekd_q[i]) * 56'(pw_out.d);
			sprod[i] = 49'(lks_q[i]) * 49'(factor_pw);
			sum[i]   = 29'(amb_q[i]) + 29'(dt_f1[i]) + 29'(st_f1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
			vld_f2 <= 1'b0;
		end else if (en) begin
			vld_f1 <= vld_pw;
			vld_f2 <= vld_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dif_f1 <= pw_out.dif_on;
			for (int i = 0; i < 3; i++) begin
				dt_f1[i] <= pw_out.dif_on ? dprod[i][55:28] : 28'd0;
				st_f1[i] <= (pw_out.dif_on && pw_out.spec_on) ? sprod[i][48:30] : 19'd0;
				shade_f2[i] <= (|sum[i][28:16]) ? 16'hFFFF : sum[i][15:0];
			end
		end
	end

	assign out_valid   = vld_f2;
	assign shade_red   = shade_f2[0];
	assign shade_green = shade_f2[1];
	assign shade_blue  = shade_f2[2];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s12) && $stable(vld_f1))
		else $error("pipe moved while stalled");

	a_ambient_only: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_f1 && !dif_f1) |=>
		shade_red == (($past(amb_q[0]) > 22'h00FFFF) ? 16'hFFFF : $past(amb_q[0][15:0])))
		else $error("ambient-only result mismatch");

endmodule

// File: rtl/core/phl_isqrt.sv
module phl_isqrt import phl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [35:0] in_v,
	input  vec_pay_t    in_pay,
	output logic        out_vld,
	output logic [17:0] out_root,
	output vec_pay_t    out_pay
);

	// one root bit per stage, two radicand bits consumed per stage
	logic [19:0] rem_s  [SQ_STEPS];
	logic [17:0] root_s [SQ_STEPS];
	logic [35:0] v_s    [SQ_STEPS];
	vec_pay_t    pay_s  [SQ_STEPS];
	logic        vld_s  [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [19:0] rem_i;
		logic [17:0] root_i;
		logic [35:0] v_i;
		vec_pay_t    pay_i;
		logic        vld_i;
		logic [21:0] r2;
		logic [21:0] trial;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign v_i    = in_v;
			assign pay_i  = in_pay;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign v_i    = v_s[k-1];
			assign pay_i  = pay_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign r2    = {rem_i, v_i[35:34]};
		assign trial = {2'b00, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= trial) begin
					rem_s[k]  <= 20'(r2 - trial);
					root_s[k] <= {root_i[16:0], 1'b1};
				end else begin
					rem_s[k]  <= r2[19:0];
					root_s[k] <= {root_i[16:0], 1'b0};
				end
				v_s[k]   <= {v_i[33:0], 2'b00};
				pay_s[k] <= pay_i;
			end
		end
	end

	assign out_vld  = vld_s[SQ_STEPS-1];
	assign out_root = root_s[SQ_STEPS-1];
	assign out_pay  = pay_s[SQ_STEPS-1];

endmodule

// File: rtl/core/phl_recip.sv
module phl_recip import phl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [17:0] in_root,
	input  vec_pay_t    in_pay,
	output logic        out_vld,
	output logic [18:0] out_rcp,
	output vec_pay_t    out_pay
);

	// 2^34 / root: the upper numerator bits give zero quotient bits since
	// root >= 2^16, so the division starts with a partial remainder of 2^15
	logic [18:0] rem_s [RC_STEPS];
	logic [18:0] quo_s [RC_STEPS];
	logic [17:0] den_s [RC_STEPS];
	vec_pay_t    pay_s [RC_STEPS];
	logic        vld_s [RC_STEPS];

	for (genvar k = 0; k < RC_STEPS; k++) begin : g_step
		logic [18:0] rem_i;
		logic [18:0] quo_i;
		logic [17:0] den_i;
		vec_pay_t    pay_i;
		logic        vld_i;
		logic [19:0] r2;

		if (k == 0) begin : g_first
			assign rem_i = 19'h08000;
			assign quo_i = '0;
			assign den_i = in_root;
			assign pay_i = in_pay;
			assign vld_i = in_vld;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign quo_i = quo_s[k-1];
			assign den_i = den_s[k-1];
			assign pay_i = pay_s[k-1];
			assign vld_i = vld_s[k-1];
		end

		assign r2 = {rem_i, 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= {2'b00, den_i}) begin
					rem_s[k] <= 19'(r2 - {2'b00, den_i});
					quo_s[k] <= {quo_i[17:0], 1'b1};
				end else begin
					rem_s[k] <= r2[18:0];
					quo_s[k] <= {quo_i[17:0], 1'b0};
				end
				den_s[k] <= den_i;
				pay_s[k] <= pay_i;
			end
		end
	end

	assign out_vld = vld_s[RC_STEPS-1];
	assign out_rcp = quo_s[RC_STEPS-1];
	assign out_pay = pay_s[RC_STEPS-1];

endmodule

// File: rtl/core/phl_power.sv
module phl_power import phl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [28:0] x,
	input  logic [15:0] sh,
	input  pw_pay_t     in_pay,
	output logic        out_vld,
	output logic [16:0] factor,
	output pw_pay_t     out_pay
);

	// x in Q1.28, already clamped to 1.0; factor = x^(sh/256) in Q1.16
	logic        vld_p1, vld_p2, vld_p3, vld_p4, vld_p5;
	pw_pay_t     pay_p1, pay_p2, pay_p3, pay_p4, pay_p5;
	logic [27:0] f_p1;
	logic [4:0]  pd_p1;
	logic [20:0] neg_p2;
	logic [28:0] t_p3;
	logic [17:0] mant_p4;
	logic [4:0]  shift_p4;
	logic        zero_p4;
	logic [16:0] factor_p5;

	logic [5:0]  p;
	logic [28:0] v;
	logic [4:0]  lidx;
	logic [15:0] lrem;
	logic [16:0] lf;
	logic [28:0] lprod;
	logic [36:0] tprod;
	logic [12:0] ip;
	logic [15:0] fr;
	logic [15:0] g;
	logic [4:0]  eidx;
	logic [24:0] eprod;

	assign p = lead_one({4'b0000, x});
	assign v = 29'(x << (6'd28 - p));

	assign lidx  = {1'b0, f_p1[27:24]};
	assign lrem  = f_p1[23:8];
	assign lprod = 29'(log_tab(lidx + 5'd1) - log_tab(lidx)) * 29'(lrem);
	assign lf    = log_tab(lidx) + 17'(lprod >> 16);

	assign tprod = 37'(neg_p2) * 37'(sh);

	assign ip    = t_p3[28:16];
	assign fr    = t_p3[15:0];
	assign g     = 16'(17'h10000 - {1'b0, fr});
	assign eidx  = {1'b0, g[15:12]};
	assign eprod = 25'(exp_tab(eidx + 5'd1) - exp_tab(eidx)) * 25'(g[11:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
			vld_p5 <= 1'b0;
		end else if (en) begin
			vld_p1 <= in_vld;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
			vld_p4 <= vld_p3;
			vld_p5 <= vld_p4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_p1   <= v[27:0];
			pd_p1  <= 5'(6'd28 - p);
			pay_p1 <= in_pay;

			neg_p2 <= 21'({pd_p1, 16'h0000}) - 21'(lf);
			pay_p2 <= pay_p1;

			t_p3   <= tprod[36:8];
			pay_p3 <= pay_p2;

			if (fr == 16'h0000) begin
				mant_p4  <= 18'h10000;
				zero_p4  <= (ip > 13'd17);
				shift_p4 <= 5'(ip);
			end else begin
				mant_p4  <= exp_tab(eidx) + 18'(eprod >> 12);
				zero_p4  <= (ip > 13'd16);
				shift_p4 <= 5'(ip + 13'd1);
			end
			pay_p4 <= pay_p3;

			factor_p5 <= zero_p4 ? 17'h00000 : 17'(mant_p4 >> shift_p4);
			pay_p5    <= pay_p4;
		end
	end

	assign out_vld = vld_p5;
	assign factor  = factor_p5;
	assign out_pay = pay_p5;

	a_factor_max: assert property (@(posedge clk) disable iff (!arst_n)
		vld_p5 |-> factor_p5 <= 17'h10000)
		else $error("power factor above 1.0");

	a_factor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_p4 && zero_p4) |=> factor_p5 == 17'h00000)
		else $error("underflowed power not zero");

endmodule
